### hw/rtl/psg_pkg.sv
`timescale 1ns / 1ps

package psg_pkg;

    typedef enum logic [1:0] {
        FUNC_SELECT = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    // register numbers with side effects or special meaning
    localparam logic [3:0] REG_NOISE_PER = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_AMP_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;
    localparam logic [3:0] REG_ROW       = 4'd14;
    localparam logic [3:0] REG_KEYS      = 4'd15;

    localparam int NUM_CH   = 3;
    localparam int NUM_REGS = 16;

    // envelope shape bits
    localparam int SHAPE_HOLD = 0;
    localparam int SHAPE_ALT  = 1;
    localparam int SHAPE_ATT  = 2;
    localparam int SHAPE_CONT = 3;

    typedef struct packed {
        t_func      func;
        logic [7:0] bus_data;
        logic [7:0] key_columns;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] row_drive;
        logic [3:0] level_a;
        logic [3:0] level_b;
        logic [3:0] level_c;
    } t_out_word;

    // controls from the register file side into the generators
    typedef struct packed {
        logic        step;
        logic        restart;
        logic [3:0]  restart_shape;
        logic [3:0]  shape;
        logic [11:0] tone_per_a;
        logic [11:0] tone_per_b;
        logic [11:0] tone_per_c;
        logic [4:0]  noise_per;
        logic [15:0] env_per;
    } t_gen_ctrl;

    // generator outputs after the current word's update
    typedef struct packed {
        logic [NUM_CH-1:0] tone;
        logic              noise;
        logic [3:0]        env_value;
    } t_gen_out;

endpackage

### hw/rtl/psg_gen.sv
`timescale 1ns / 1ps

module psg_gen (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psg_pkg::t_gen_ctrl i_ctrl,
    output psg_pkg::t_gen_out  o_next
);
    import psg_pkg::*;

    logic [11:0] r_tone_cnt [NUM_CH];
    logic [11:0] n_tone_cnt [NUM_CH];
    logic [NUM_CH-1:0] r_tone, n_tone;
    logic [4:0]  r_noise_cnt, n_noise_cnt;
    logic [16:0] r_noise_shift, n_noise_shift;
    logic        r_noise, n_noise;
    logic [15:0] r_env_cnt, n_env_cnt;
    logic [4:0]  r_env_pos, n_env_pos;
    logic [3:0]  r_env_val, n_env_val;
    logic [3:0]  r_env_mask, n_env_mask;
    logic        r_env_frozen, n_env_frozen;
    logic        r_half, n_half;

    logic [11:0] tone_per [NUM_CH];

    assign tone_per[0] = i_ctrl.tone_per_a;
    assign tone_per[1] = i_ctrl.tone_per_b;
    assign tone_per[2] = i_ctrl.tone_per_c;

    always_comb begin
        logic [12:0] t_next;
        logic [11:0] t_per;
        logic [5:0]  nz_next;
        logic [4:0]  nz_per;
        logic [16:0] ev_next;
        logic [15:0] ev_per;
        logic [4:0]  pos;
        logic [3:0]  msk;

        t_next = 13'd0;
        t_per  = 12'd0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_tone_cnt[ch] = r_tone_cnt[ch];
        end
        n_tone        = r_tone;
        n_noise_cnt   = r_noise_cnt;
        n_noise_shift = r_noise_shift;
        n_noise       = r_noise;
        n_env_cnt     = r_env_cnt;
        n_env_pos     = r_env_pos;
        n_env_val     = r_env_val;
        n_env_mask    = r_env_mask;
        n_env_frozen  = r_env_frozen;
        n_half        = r_half;

        nz_per  = (i_ctrl.noise_per == 5'd0) ? 5'd1 : i_ctrl.noise_per;
        ev_per  = (i_ctrl.env_per == 16'd0) ? 16'd1 : i_ctrl.env_per;
        nz_next = {1'b0, r_noise_cnt} + 6'd1;
        ev_next = {1'b0, r_env_cnt} + 17'd1;
        pos     = r_env_pos + 5'd1;
        msk     = i_ctrl.shape[SHAPE_ALT] ? ~r_env_mask : r_env_mask;

        if (i_ctrl.step) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                t_per  = (tone_per[ch] == 12'd0) ? 12'd1 : tone_per[ch];
                t_next = {1'b0, r_tone_cnt[ch]} + 13'd1;
                if (t_next >= {1'b0, t_per}) begin
                    n_tone_cnt[ch] = 12'd0;
                    n_tone[ch]     = ~r_tone[ch];
                end else begin
                    n_tone_cnt[ch] = t_next[11:0];
                end
            end
            n_half = ~r_half;
            // noise and envelope run at half the tick rate
            if (!r_half) begin
                if (nz_next >= {1'b0, nz_per}) begin
                    n_noise_cnt   = 5'd0;
                    n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[3],
                                     r_noise_shift[16:1]};
                    n_noise       = r_noise_shift[1];
                end else begin
                    n_noise_cnt = nz_next[4:0];
                end
                if (ev_next >= {1'b0, ev_per}) begin
                    n_env_cnt = 16'd0;
                    if (!r_env_frozen) begin
                        n_env_pos = pos;
                        if (!pos[4]) begin
                            n_env_val = pos[3:0] ^ r_env_mask;
                        end else if (!i_ctrl.shape[SHAPE_CONT]) begin
                            n_env_val    = 4'd0;
                            n_env_frozen = 1'b1;
                        end else begin
                            n_env_mask = msk;
                            if (i_ctrl.shape[SHAPE_HOLD]) begin
                                n_env_val    = ~msk;
                                n_env_frozen = 1'b1;
                            end else begin
                                n_env_pos = 5'd0;
                                n_env_val = msk;
                            end
                        end
                    end
                end else begin
                    n_env_cnt = ev_next[15:0];
                end
            end
        end

        if (i_ctrl.restart) begin
            n_env_mask   = i_ctrl.restart_shape[SHAPE_ATT] ? 4'h0 : 4'hf;
            n_env_pos    = 5'd0;
            n_env_frozen = 1'b0;
            n_env_cnt    = 16'd0;
            n_env_val    = i_ctrl.restart_shape[SHAPE_ATT] ? 4'h0 : 4'hf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_tone_cnt[ch] <= 12'd0;
            end
            r_tone        <= '0;
            r_noise_cnt   <= 5'd0;
            r_noise_shift <= 17'd1;
            r_noise       <= 1'b0;
            r_env_cnt     <= 16'd0;
            r_env_pos     <= 5'd0;
            r_env_val     <= 4'd0;
            r_env_mask    <= 4'd0;
            r_env_frozen  <= 1'b0;
            r_half        <= 1'b0;
        end else begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_tone_cnt[ch] <= n_tone_cnt[ch];
            end
            r_tone        <= n_tone;
            r_noise_cnt   <= n_noise_cnt;
            r_noise_shift <= n_noise_shift;
            r_noise       <= n_noise;
            r_env_cnt     <= n_env_cnt;
            r_env_pos     <= n_env_pos;
            r_env_val     <= n_env_val;
            r_env_mask    <= n_env_mask;
            r_env_frozen  <= n_env_frozen;
            r_half        <= n_half;
        end
    end

    assign o_next.tone      = n_tone;
    assign o_next.noise     = n_noise;
    assign o_next.env_value = n_env_val;

`ifndef SYNTH
    // LFSR must never lock up at all zeros
    a_lfsr_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_noise_shift != 17'd0)
        else $error("noise LFSR reached zero");

    a_env_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env_pos <= 5'd16)
        else $error("envelope position out of range");

    // a held envelope only moves on a restart
    a_env_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_env_frozen && !i_ctrl.restart) |=> $stable(r_env_val))
        else $error("frozen envelope changed");
`endif

endmodule

### hw/rtl/psg_tone_noise_envelope.sv
`timescale 1ns / 1ps

// Three-channel tone/noise/envelope sound generator with a sixteen-entry
// register file. Each input word is one operation: select a register, write
// it, read it (register 15 reads back the inverted key columns), or advance
// the generators by one tick. Every word gives exactly one output word with
// the read data (zero unless a read), the keyboard row drive and the three
// gated channel levels as they stand after that operation. One word is taken
// per clock while the output is not stalled; a word is first held in the
// input register and then one state update pass lands it in the result
// register. The input register also acts as the skid stage: a word is still
// accepted while a finished result is held by a stall, and input stall only
// rises when both registers are full and the output is stalled. Noise and
// envelope dividers step on every second tick; a zero period behaves as a
// period of one. Writing register 13 restarts the envelope; writing register
// 14 sets the row drive to the complement.

module psg_tone_noise_envelope (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  psg_pkg::t_in_word  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output psg_pkg::t_out_word o_out
);
    import psg_pkg::*;

    // input register (doubles as skid stage)
    logic      r_in_valid;
    t_in_word  r_in;

    // result register
    logic      r_out_valid;
    t_out_word r_out, n_out;

    // architectural state
    logic [7:0] r_regs [NUM_REGS];
    logic [7:0] n_regs [NUM_REGS];
    logic [3:0] r_sel, n_sel;
    logic [7:0] r_row, n_row;

    logic      advance;
    logic      in_accept;
    logic [7:0] rd_data;
    t_gen_ctrl gen_ctrl;
    t_gen_out  gen_next;
    logic [3:0] level [NUM_CH];

    // word moves from input to result register when the result slot frees
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // bus side: select, write, read
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
        end
        n_sel = r_sel;
        n_row = r_row;
        rd_data = 8'd0;

        if (advance) begin
            unique case (r_in.func)
                FUNC_SELECT: n_sel = r_in.bus_data[3:0];
                FUNC_WRITE: begin
                    n_regs[r_sel] = r_in.bus_data;
                    if (r_sel == REG_ROW) begin
                        n_row = ~r_in.bus_data;
                    end
                end
                FUNC_READ: begin
                    if (r_sel == REG_KEYS) begin
                        rd_data = ~r_in.key_columns;
                    end else begin
                        rd_data = r_regs[r_sel];
                    end
                end
                FUNC_TICK: ;
                default: ;
            endcase
        end
    end

    // period/shape come from the current file; writes and ticks are exclusive
    assign gen_ctrl.step          = advance && (r_in.func == FUNC_TICK);
    assign gen_ctrl.restart       = advance && (r_in.func == FUNC_WRITE) &&
                                    (r_sel == REG_ENV_SHAPE);
    assign gen_ctrl.restart_shape = r_in.bus_data[3:0];
    assign gen_ctrl.shape         = r_regs[REG_ENV_SHAPE][3:0];
    assign gen_ctrl.tone_per_a    = {r_regs[1][3:0], r_regs[0]};
    assign gen_ctrl.tone_per_b    = {r_regs[3][3:0], r_regs[2]};
    assign gen_ctrl.tone_per_c    = {r_regs[5][3:0], r_regs[4]};
    assign gen_ctrl.noise_per     = r_regs[REG_NOISE_PER][4:0];
    assign gen_ctrl.env_per       = {r_regs[REG_ENV_HI], r_regs[REG_ENV_LO]};

    psg_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (gen_ctrl),
        .o_next  (gen_next)
    );

    // mixer: enables are active low, levels come from the updated file
    always_comb begin
        logic       tone_ok;
        logic       noise_ok;
        logic [7:0] amp;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tone_ok  = gen_next.tone[ch] || n_regs[REG_MIXER][ch];
            noise_ok = gen_next.noise || n_regs[REG_MIXER][ch + NUM_CH];
            amp      = n_regs[REG_AMP_A + 4'(ch)];
            if (tone_ok && noise_ok) begin
                level[ch] = amp[4] ? gen_next.env_value : amp[3:0];
            end else begin
                level[ch] = 4'd0;
            end
        end
    end

    assign n_out.read_data = rd_data;
    assign n_out.row_drive = n_row;
    assign n_out.level_a   = level[0];
    assign n_out.level_b   = level[1];
    assign n_out.level_c   = level[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_sel <= 4'd0;
            r_row <= 8'd0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= n_regs[i];
            end
            r_sel <= n_sel;
            r_row <= n_row;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_row_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.func == FUNC_WRITE && r_sel == REG_ROW)
        |=> (o_out.row_drive == ~$past(r_in.bus_data)))
        else $error("row drive not complement of row write");

    a_key_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.func == FUNC_READ && r_sel == REG_KEYS)
        |=> (o_out.read_data == ~$past(r_in.key_columns)))
        else $error("key column read wrong");

    a_quiet_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.func != FUNC_READ) |=> (o_out.read_data == 8'd0))
        else $error("read data not zero on non-read word");

    // a waiting word must not be overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost a word");
`endif

endmodule
